>>> design/stack_machine_execute_top_assert.svh
// assertion macros used by the stack machine top-level design file
`ifndef STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SME_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("stack machine check failed");

// consequence holds in the same cycle as the antecedent
`define SME_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack machine check failed");

// consequence holds in the cycle after the antecedent
`define SME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack machine check failed");

`endif

>>> design/sme_pkg.sv
`default_nettype none

package sme_pkg;

   // default number of stack entries
   localparam int STACK_DEPTH_DEF = 128;

   localparam int WORD_W = 32;
   localparam int KIND_W = 4;

   // opcodes, carried in the tuser field of the request word
   typedef enum logic [KIND_W-1:0] {
      OP_CONST   = 4'd0,
      OP_ADD     = 4'd1,
      OP_EMIT    = 4'd2,
      OP_DROP    = 4'd3,
      OP_GET     = 4'd4,
      OP_SET     = 4'd5,
      OP_CMP     = 4'd6,
      OP_JGT     = 4'd7,
      OP_HALT    = 4'd8
   } op_type;

   // one result word
   typedef struct packed {
      logic [WORD_W-1:0] pc_advance;
      logic              print_valid;
      logic [WORD_W-1:0] data_value;
      logic              halted;
      logic              fault;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/sme_stack_ram.sv
`default_nettype none

module sme_stack_ram #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [sme_pkg::WORD_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr_a,
   input  wire logic [ADDR_W-1:0]         rd_addr_b,
   output logic      [sme_pkg::WORD_W-1:0] rd_data_a,
   output logic      [sme_pkg::WORD_W-1:0] rd_data_b
);
   import sme_pkg::*;

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   // one write port, two registered read ports, old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

>>> design/sme_exec.sv
`default_nettype none

module sme_exec #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
   parameter int LVL_W       = $clog2(STACK_DEPTH + 1),
   parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
   input  wire sme_pkg::op_type           kind,
   input  wire logic [sme_pkg::WORD_W-1:0] operand,
   input  wire logic [LVL_W-1:0]          level,
   input  wire logic [sme_pkg::WORD_W-1:0] word_a,
   input  wire logic [sme_pkg::WORD_W-1:0] word_b,
   output logic                           wr_en,
   output logic      [ADDR_W-1:0]         wr_addr,
   output logic      [sme_pkg::WORD_W-1:0] wr_data,
   output logic      [LVL_W-1:0]          level_next,
   output sme_pkg::rsp_type               result
);
   import sme_pkg::*;

   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(STACK_DEPTH);
   localparam logic [WORD_W-1:0] ADV_ONE = WORD_W'(1);
   localparam logic [WORD_W-1:0] ADV_TWO = WORD_W'(2);

   logic [LVL_W-1:0]  lvl_inc;
   logic [LVL_W-1:0]  lvl_dec1;
   logic [LVL_W-1:0]  lvl_dec2;
   logic [LVL_W-1:0]  set_lvl;
   logic              opnd_neg;
   logic              fault;
   logic [WORD_W-1:0] cmp_word;
   logic              a_positive;

   // level arithmetic and operand checks
   always_comb begin
      lvl_inc    = level + LVL_W'(1);
      lvl_dec1   = level - LVL_W'(1);
      lvl_dec2   = level - LVL_W'(2);
      set_lvl    = lvl_dec2 - operand[LVL_W-1:0];
      opnd_neg   = operand[WORD_W-1];
      a_positive = !word_a[WORD_W-1] && (word_a != '0);
      if ($signed(word_b) > $signed(word_a)) begin
         cmp_word = ADV_ONE;
      end else if ($signed(word_b) < $signed(word_a)) begin
         cmp_word = '1;
      end else begin
         cmp_word = '0;
      end
   end

   // opcode decode: stack update and result word
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = level[ADDR_W-1:0];
      wr_data    = operand;
      level_next = level;
      result     = '0;
      fault      = 1'b0;
      unique case (kind)
         OP_CONST: begin
            fault             = (level >= FULL_LVL);
            wr_en             = 1'b1;
            level_next        = lvl_inc;
            result.pc_advance = ADV_TWO;
         end
         OP_ADD: begin
            fault             = (level < LVL_W'(2));
            wr_en             = 1'b1;
            wr_addr           = lvl_dec2[ADDR_W-1:0];
            wr_data           = word_b + word_a;
            level_next        = lvl_dec1;
            result.pc_advance = ADV_ONE;
         end
         OP_EMIT: begin
            fault              = (level == '0);
            level_next         = lvl_dec1;
            result.pc_advance  = ADV_ONE;
            result.print_valid = 1'b1;
            result.data_value  = word_a;
         end
         OP_DROP: begin
            fault             = (level == '0);
            level_next        = lvl_dec1;
            result.pc_advance = ADV_ONE;
         end
         OP_GET: begin
            fault             = (level == '0) || (level >= FULL_LVL) || opnd_neg
                                || (operand >= WORD_W'(level));
            wr_en             = 1'b1;
            wr_data           = word_a;
            level_next        = lvl_inc;
            result.pc_advance = ADV_TWO;
         end
         OP_SET: begin
            fault             = (level < LVL_W'(2)) || opnd_neg
                                || (operand >= WORD_W'(lvl_dec1));
            wr_en             = 1'b1;
            wr_addr           = set_lvl[ADDR_W-1:0];
            wr_data           = word_a;
            level_next        = lvl_dec1;
            result.pc_advance = ADV_TWO;
         end
         OP_CMP: begin
            fault             = (level < LVL_W'(2));
            wr_en             = 1'b1;
            wr_addr           = lvl_dec2[ADDR_W-1:0];
            wr_data           = cmp_word;
            level_next        = lvl_dec1;
            result.pc_advance = ADV_ONE;
         end
         OP_JGT: begin
            fault             = (level == '0);
            level_next        = lvl_dec1;
            result.pc_advance = a_positive ? operand : ADV_TWO;
         end
         OP_HALT: begin
            fault             = (level == '0);
            result.data_value = word_a;
            result.halted     = 1'b1;
         end
         default: begin
            fault = 1'b1;
         end
      endcase
      // a fault leaves the stack untouched and clears every other field
      if (fault) begin
         wr_en        = 1'b0;
         level_next   = level;
         result       = '0;
         result.fault = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> design/stack_machine_execute_top.sv
// an accepted request word waits in the stage register; rsp_tvalid rises once it moves into the result register
// throughput: one instruction per cycle, stalls only under rsp backpressure
// rate is set by the stack ram's registered read and the result register
// reset clears the stack level and all valid flags; stack contents are not
// cleared, so no clearing pass is needed and requests are taken at once
`default_nettype none

module stack_machine_execute_top #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] operand
   input  wire logic [3:0]  req_tuser,  // [3:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,  // [31:0] pc_advance, [63:32] data_value
   output logic      [2:0]  rsp_tuser   // [0] print_valid, [1] halted, [2] fault
);
   import sme_pkg::*;

   `include "stack_machine_execute_top_assert.svh"

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // stage register (instruction plus captured operands) and result register
   logic              stage_valid_ff, stage_valid_in;
   op_type            stage_kind_ff;
   logic [WORD_W-1:0] stage_operand_ff;
   logic              byp_a_ff, byp_a_in;
   logic              byp_b_ff, byp_b_in;
   logic [WORD_W-1:0] byp_data_ff;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_res_ff;

   logic              req_accept;
   logic              exec;
   logic [LVL_W-1:0]  lvl_pre;
   logic [LVL_W-1:0]  lvl_a;
   logic [LVL_W-1:0]  lvl_b;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [WORD_W-1:0] rd_data_a;
   logic [WORD_W-1:0] rd_data_b;
   logic [WORD_W-1:0] word_a;
   logic [WORD_W-1:0] word_b;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [LVL_W-1:0]  level_next;
   rsp_type           result;

   // handshake: stage executes when the result register can take a word
   always_comb begin
      exec       = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !stage_valid_ff || exec;
      req_accept = req_tvalid && req_tready;
   end

   // read addresses for the incoming word, seen from the level after the stage
   always_comb begin
      lvl_pre = exec ? level_next : level_ff;
      if (op_type'(req_tuser) == OP_GET) begin
         lvl_a = lvl_pre - LVL_W'(1) - req_tdata[LVL_W-1:0];
      end else begin
         lvl_a = lvl_pre - LVL_W'(1);
      end
      lvl_b     = lvl_pre - LVL_W'(2);
      rd_addr_a = lvl_a[ADDR_W-1:0];
      rd_addr_b = lvl_b[ADDR_W-1:0];
      byp_a_in  = exec && wr_en && (wr_addr == rd_addr_a);
      byp_b_in  = exec && wr_en && (wr_addr == rd_addr_b);
   end

   sme_stack_ram #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en && exec),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (req_accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // forward the write that landed in the same cycle as the read
   always_comb begin
      word_a = byp_a_ff ? byp_data_ff : rd_data_a;
      word_b = byp_b_ff ? byp_data_ff : rd_data_b;
   end

   sme_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .LVL_W       (LVL_W),
      .ADDR_W      (ADDR_W)
   ) u_exec (
      .kind       (stage_kind_ff),
      .operand    (stage_operand_ff),
      .level      (level_ff),
      .word_a     (word_a),
      .word_b     (word_b),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .level_next (level_next),
      .result     (result)
   );

   // next-state for control registers
   always_comb begin
      stage_valid_in = req_accept || (stage_valid_ff && !exec);
      level_in       = exec ? level_next : level_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         level_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         byp_a_ff       <= 1'b0;
         byp_b_ff       <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         level_ff       <= level_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (req_accept) begin
            byp_a_ff <= byp_a_in;
            byp_b_ff <= byp_b_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff    <= op_type'(req_tuser);
         stage_operand_ff <= req_tdata;
         byp_data_ff      <= wr_data;
      end
      if (exec) begin
         rsp_res_ff <= result;
      end
   end

   // result port
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {rsp_res_ff.data_value, rsp_res_ff.pc_advance};
      rsp_tuser  = {rsp_res_ff.fault, rsp_res_ff.halted, rsp_res_ff.print_valid};
   end

   // checks
   `SME_ASSERT_ALWAYS(a_level_in_range, clock, reset, level_ff <= LVL_W'(STACK_DEPTH))
   `SME_ASSERT_NEXT(a_fault_keeps_level, clock, reset, exec && result.fault, $stable(level_ff))
   `SME_ASSERT_NEXT(a_idle_keeps_level, clock, reset, !exec, $stable(level_ff))
   `SME_ASSERT_IMPLY(a_fault_clears_fields, clock, reset, exec && result.fault, (result.pc_advance == '0) && !result.print_valid && !result.halted && !wr_en)

endmodule

`default_nettype wire

>>> sim/tb_stack_machine_execute_top.sv
`timescale 1ns / 100ps

module tb_stack_machine_execute_top;
   import sme_pkg::*;

   localparam int DEPTH          = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 1200;
   localparam int HOLD_CYCLES    = 100;
   localparam int HOLD_AT        = 500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;
   localparam int MAX_PRINTED    = 25;

   // opcodes the block does not know
   localparam logic [3:0] UNKNOWN_LO = 4'd9;
   localparam logic [3:0] UNKNOWN_HI = 4'd15;

   typedef struct {
      logic [3:0]  kind;
      logic [31:0] opnd;
      bit          pinned;
      rsp_type     want;
   } instr_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] operand
   logic [3:0]  req_tuser = '0;   // [3:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [31:0] pc_advance, [63:32] data_value
   logic [2:0]  rsp_tuser;        // [0] print_valid, [1] halted, [2] fault

   // fixed expectation travelling alongside the word on the bus
   bit          row_pinned = 1'b0;
   rsp_type     row_pin = '0;

   // predicted machine state
   logic [31:0] stack_mem [DEPTH];
   int          stack_level = 0;
   int          deepest = 0;

   rsp_type       pending_rsp [$];
   instr_row_type rows [$];
   int          n_errors = 0;
   int          n_words_in = 0;
   int          n_results = 0;
   int          n_faults = 0;
   int          n_halts = 0;
   int          n_prints = 0;
   int          quiet_cycles = 0;
   bit          climbing = 1'b1;
   bit          rsp_hold = 1'b0;
   bit          hold_done = 1'b0;

   stack_machine_execute_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // execute one instruction on the predicted stack
   function automatic rsp_type execute_instr(input logic [3:0] kind, input logic [31:0] opnd);
      rsp_type     r;
      logic [31:0] top;
      int          lv;
      int          next_lv;
      int          depth;
      bit          ok;
      r       = '0;
      lv      = stack_level;
      next_lv = lv;
      ok      = 1'b0;
      // negative or huge depths can never be in range
      depth   = (opnd[31] || opnd >= DEPTH) ? DEPTH : int'(opnd);
      top     = (lv > 0) ? stack_mem[lv-1] : '0;
      case (kind)
         OP_CONST: begin
            if (lv < DEPTH) begin
               stack_mem[lv] = opnd;
               next_lv = lv + 1;
               r.pc_advance = 32'd2;
               ok = 1'b1;
            end
         end
         OP_ADD: begin
            if (lv >= 2) begin
               stack_mem[lv-2] = stack_mem[lv-2] + top;
               next_lv = lv - 1;
               r.pc_advance = 32'd1;
               ok = 1'b1;
            end
         end
         OP_EMIT: begin
            if (lv >= 1) begin
               next_lv = lv - 1;
               r.pc_advance = 32'd1;
               r.print_valid = 1'b1;
               r.data_value = top;
               ok = 1'b1;
            end
         end
         OP_DROP: begin
            if (lv >= 1) begin
               next_lv = lv - 1;
               r.pc_advance = 32'd1;
               ok = 1'b1;
            end
         end
         OP_GET: begin
            if (lv < DEPTH && depth < lv) begin
               stack_mem[lv] = stack_mem[lv-1-depth];
               next_lv = lv + 1;
               r.pc_advance = 32'd2;
               ok = 1'b1;
            end
         end
         OP_SET: begin
            // depth counts from the top after the pop
            if (lv >= 2 && depth < lv - 1) begin
               stack_mem[lv-2-depth] = top;
               next_lv = lv - 1;
               r.pc_advance = 32'd2;
               ok = 1'b1;
            end
         end
         OP_CMP: begin
            if (lv >= 2) begin
               if ($signed(stack_mem[lv-2]) > $signed(top))
                  stack_mem[lv-2] = 32'd1;
               else if ($signed(stack_mem[lv-2]) < $signed(top))
                  stack_mem[lv-2] = '1;
               else
                  stack_mem[lv-2] = '0;
               next_lv = lv - 1;
               r.pc_advance = 32'd1;
               ok = 1'b1;
            end
         end
         OP_JGT: begin
            if (lv >= 1) begin
               next_lv = lv - 1;
               r.pc_advance = (!top[31] && top != '0) ? opnd : 32'd2;
               ok = 1'b1;
            end
         end
         OP_HALT: begin
            // top is returned but stays on the stack
            if (lv >= 1) begin
               r.data_value = top;
               r.halted = 1'b1;
               ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (ok) begin
         stack_level = next_lv;
         if (next_lv > deepest)
            deepest = next_lv;
      end else begin
         r = '0;
         r.fault = 1'b1;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (n_errors < MAX_PRINTED)
         $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      n_errors++;
   endtask

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'h0000_0000;
         1: v = 32'hFFFF_FFFF;
         2: v = 32'h7FFF_FFFF;
         3: v = 32'h8000_0000;
         4: v = $urandom_range(0, 15);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // depth for get (skew 0) or set (skew 1), occasionally out of range
   function automatic logic [31:0] pick_depth(input int lv, input int skew);
      logic [31:0] d;
      if (lv - skew <= 0 || $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 2))
            0: d = (lv - skew < 0) ? 32'd0 : 32'(lv - skew);
            1: d = 32'hFFFF_FFFF;
            default: d = $urandom();
         endcase
      end else begin
         d = $urandom_range(0, lv - 1 - skew);
      end
      return d;
   endfunction

   // random instruction, alternating between filling and draining the stack
   task automatic pick_instr(output logic [3:0] kind, output logic [31:0] opnd);
      int lv;
      int roll;
      lv = stack_level;
      if (lv == DEPTH && $urandom_range(0, 4) == 0)
         climbing = 1'b0;
      else if (lv == 0 && $urandom_range(0, 3) == 0)
         climbing = 1'b1;
      else if ($urandom_range(0, 99) == 0)
         climbing = !climbing;
      roll = $urandom_range(0, 99);
      opnd = $urandom();
      if (roll < 3) begin
         kind = 4'($urandom_range(UNKNOWN_LO, UNKNOWN_HI));
      end else if (roll < (climbing ? 78 : 18)) begin
         if ($urandom_range(0, 3) == 0) begin
            kind = OP_GET;
            opnd = pick_depth(lv, 0);
         end else begin
            kind = OP_CONST;
            opnd = pick_value();
         end
      end else begin
         case ($urandom_range(0, 6))
            0: kind = OP_ADD;
            1: kind = OP_EMIT;
            2: kind = OP_DROP;
            3: begin
               kind = OP_SET;
               opnd = pick_depth(lv, 1);
            end
            4: kind = OP_CMP;
            5: begin
               kind = OP_JGT;
               if ($urandom_range(0, 1) == 0)
                  opnd = 32'($signed($urandom_range(0, 31)) - 16);
            end
            default: kind = OP_HALT;
         endcase
      end
   endtask

   task automatic add_row(input logic [3:0] kind, input logic [31:0] opnd, input bit pinned,
                          input logic [31:0] pc, input logic pv, input logic [31:0] data,
                          input logic halted, input logic fault);
      instr_row_type row;
      row.kind              = kind;
      row.opnd              = opnd;
      row.pinned            = pinned;
      row.want.pc_advance   = pc;
      row.want.print_valid  = pv;
      row.want.data_value   = data;
      row.want.halted       = halted;
      row.want.fault        = fault;
      rows.push_back(row);
   endtask

   // offer one word from a falling edge and hold it until taken
   task automatic drive_word(input logic [3:0] kind, input logic [31:0] opnd, input bit pinned,
                             input rsp_type pin_val, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= opnd;
      row_pinned <= pinned;
      row_pin    <= pin_val;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // result checking and prediction at the rising edge
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.pc_advance  = rsp_tdata[31:0];
            got.data_value  = rsp_tdata[63:32];
            got.print_valid = rsp_tuser[0];
            got.halted      = rsp_tuser[1];
            got.fault       = rsp_tuser[2];
            n_results++;
            n_faults += got.fault;
            n_halts  += got.halted;
            n_prints += got.print_valid;
            if (pending_rsp.size() == 0) begin
               flag_mismatch("result word with nothing outstanding", '0, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (got.pc_advance !== want.pc_advance)
                  flag_mismatch("pc_advance", got.pc_advance, want.pc_advance);
               if (got.print_valid !== want.print_valid)
                  flag_mismatch("print_valid", 32'(got.print_valid), 32'(want.print_valid));
               if (got.data_value !== want.data_value)
                  flag_mismatch("data_value", got.data_value, want.data_value);
               if (got.halted !== want.halted)
                  flag_mismatch("halted", 32'(got.halted), 32'(want.halted));
               if (got.fault !== want.fault)
                  flag_mismatch("fault", 32'(got.fault), 32'(want.fault));
            end
         end
         if (req_tvalid && req_tready) begin
            n_words_in++;
            want = execute_instr(req_tuser, req_tdata);
            if (row_pinned)
               want = row_pin;
            pending_rsp.push_back(want);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_rsp.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, calm stretches and one long hold-off
   initial begin : rsp_side
      int stall_left;
      int cyc;
      stall_left = 0;
      cyc = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (!hold_done && n_results >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_hold = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ((cyc % 300) >= 60 && $urandom_range(0, 99) < 12)
               stall_left = idle_len();
         end
      end
   end

   initial begin : stimulus
      logic [3:0]  kind;
      logic [31:0] opnd;
      int          gap;

      // empty stack: everything that pops faults
      add_row(OP_ADD,     32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_EMIT,    32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_DROP,    32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_HALT,    32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_JGT,     32'd7,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(UNKNOWN_HI, 32'hFFFF_FFFF, 1, 32'd0, 0, 32'd0, 0, 1);
      // one entry: bad depths and underflow of two-operand ops
      add_row(OP_CONST,   32'h7FFF_FFFF, 1, 32'd2, 0, 32'd0, 0, 0);
      add_row(OP_GET,     32'd1,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_GET,     32'hFFFF_FFFF, 1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_SET,     32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_CMP,     32'd0,         1, 32'd0, 0, 32'd0, 0, 1);
      // largest against smallest, then halt keeps the top
      add_row(OP_CONST,   32'h8000_0000, 1, 32'd2, 0, 32'd0, 0, 0);
      add_row(OP_SET,     32'd1,         1, 32'd0, 0, 32'd0, 0, 1);
      add_row(OP_CMP,     32'd0,         1, 32'd1, 0, 32'd0, 0, 0);
      add_row(OP_HALT,    32'd0,         1, 32'd0, 0, 32'd1, 1, 0);
      // equal compare, jump not taken on zero
      add_row(OP_GET,     32'd0,         1, 32'd2, 0, 32'd0, 0, 0);
      add_row(OP_CMP,     32'd0,         0, 32'd0, 0, 32'd0, 0, 0);
      add_row(OP_JGT,     32'h8000_0000, 1, 32'd2, 0, 32'd0, 0, 0);
      // wrapping add, set, print, taken jump
      add_row(OP_CONST,   32'hFFFF_FFFF, 1, 32'd2, 0, 32'd0, 0, 0);
      add_row(OP_GET,     32'd0,         0, 32'd0, 0, 32'd0, 0, 0);
      add_row(OP_ADD,     32'd0,         0, 32'd0, 0, 32'd0, 0, 0);
      add_row(OP_CONST,   32'd3,         0, 32'd0, 0, 32'd0, 0, 0);
      add_row(OP_SET,     32'd0,         1, 32'd2, 0, 32'd0, 0, 0);
      add_row(OP_GET,     32'd0,         0, 32'd0, 0, 32'd0, 0, 0);
      add_row(OP_EMIT,    32'd0,         1, 32'd1, 1, 32'd3, 0, 0);
      add_row(OP_JGT,     32'h8000_0000, 1, 32'h8000_0000, 0, 32'd0, 0, 0);

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         drive_word(rows[i].kind, rows[i].opnd, rows[i].pinned, rows[i].want, idle_len());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick_instr(kind, opnd);
         gap = (rsp_hold || (n % 150) < 40) ? 0 : idle_len();
         drive_word(kind, opnd, 1'b0, '0, gap);
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the pipeline
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d instructions, %0d results: %0d faults, %0d halts, %0d prints",
               n_words_in, n_results, n_faults, n_halts, n_prints);
      $display("deepest stack %0d of %0d, %0d mismatches", deepest, DEPTH, n_errors);
      if (n_errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
